// ===== design/ttl_expiry_table_unit_macros.svh =====
// Assertion helpers for the expiry table
`ifndef TTL_EXPIRY_TABLE_UNIT_MACROS_SVH
`define TTL_EXPIRY_TABLE_UNIT_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define TTE_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define TTE_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tte_pkg.sv =====
`timescale 1ns / 1ps
package tte_pkg;
    localparam int SLOTS     = 64;
    localparam int MAX_EXP   = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(MAX_EXP + 1);
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_CHECK    = 1'b1;

    localparam logic [2:0] ST_SCHEDULED = 3'd0;
    localparam logic [2:0] ST_IGNORED   = 3'd1;
    localparam logic [2:0] ST_STALE     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_NONE_DUE  = 3'd5;

    // One table entry as stored in memory
    typedef struct packed {
        logic [15:0] key;
        logic [47:0] deadline;
        logic [63:0] revision;
        logic [63:0] generation;
    } t_entry;

    // Memory port bundle from the controller
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_mem_req;
endpackage

// ===== design/tte_if.sv =====
`timescale 1ns / 1ps
interface tte_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] key_id;
    logic signed [31:0] ttl_ms;
    logic signed [63:0] revision;
    logic [63:0] generation;
    logic [47:0] now_ms;
    modport source (output valid, opcode, key_id, ttl_ms, revision, generation, now_ms,
                    input ready);
    modport sink   (input valid, opcode, key_id, ttl_ms, revision, generation, now_ms,
                    output ready);
endinterface

interface tte_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] expired_key;
    logic signed [63:0] expired_revision;
    logic [63:0] expired_generation;
    logic        last;
    modport source (output valid, status, expired_key, expired_revision,
                    expired_generation, last, input ready);
    modport sink   (input valid, status, expired_key, expired_revision,
                    expired_generation, last, output ready);
endinterface

// ===== design/tte_mem.sv =====
`timescale 1ns / 1ps
module tte_mem
    import tte_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);
    t_entry r_mem [SLOTS];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            o_rd_data <= r_mem[i_req.rd_addr];
        end
    end
endmodule

// ===== design/tte_ctrl.sv =====
`timescale 1ns / 1ps
module tte_ctrl
    import tte_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    tte_in_if.sink   in_if,
    tte_out_if.source out_if,
    output t_mem_req o_req,
    input  t_entry   i_rd_data
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DEC   = 6'b000100,
        S_FETCH = 6'b001000,
        S_EMIT  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic   r_op;
    logic [15:0] r_key;
    logic [31:0] r_ttl;
    logic [63:0] r_rev;
    logic [63:0] r_gen;
    logic [47:0] r_now;
    logic [SLOTS-1:0] r_valid;
    logic [SLOT_W:0]  r_idx;      // address issued
    logic             r_rd_vld;   // data for r_slot arrives this cycle
    logic [SLOT_W-1:0] r_slot;
    logic             r_found;
    logic [SLOT_W-1:0] r_found_slot;
    t_entry           r_found_ent;
    logic             r_best_ok;
    logic [SLOT_W-1:0] r_best;
    logic [47:0]      r_best_dl;
    logic [CNT_W-1:0] r_count;

    // output register
    logic        r_ovalid;
    logic [2:0]  r_status;
    logic [15:0] r_okey;
    logic [63:0] r_orev;
    logic [63:0] r_ogen;
    logic        r_olast;

    logic [48:0] sum;
    logic [47:0] deadline;
    logic        stale;
    logic        free_any;
    logic [SLOT_W-1:0] free_slot;
    logic        out_free;
    logic        last_word;   // held expired word is the final one of the check
    logic        emit;        // output register loads a new word this cycle

    assign out_free = !r_ovalid || out_if.ready;
    assign in_if.ready = (r_state == S_IDLE);
    assign out_if.valid = r_ovalid;
    assign out_if.status = r_status;
    assign out_if.expired_key = r_okey;
    assign out_if.expired_revision = r_orev;
    assign out_if.expired_generation = r_ogen;
    assign out_if.last = r_olast;

    assign last_word = (r_count == CNT_W'(MAX_EXP)) || !r_best_ok;
    assign emit = out_free &&
                  ((r_state == S_OUT) ||
                   (r_state == S_DEC && (r_op == OP_SCHEDULE ||
                                         (r_count == '0 && !r_best_ok))));

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign sum = {1'b0, r_now} + {17'd0, r_ttl};
    assign deadline = sum[48] ? TIME_MAX : sum[47:0];
    assign stale = ($signed(r_rev) < $signed(r_found_ent.revision)) ||
                   (r_rev == r_found_ent.revision && r_gen < r_found_ent.generation);

    // memory requests
    always_comb begin
        o_req = '0;
        o_req.rd_en = (r_state == S_SCAN) && !r_idx[SLOT_W];
        o_req.rd_addr = r_idx[SLOT_W-1:0];
        if (r_state == S_FETCH) begin
            o_req.rd_en = 1'b1;
            o_req.rd_addr = r_best;
        end
        if (r_state == S_DEC && r_op == OP_SCHEDULE && r_ttl != 32'd0 && !r_ttl[31]
            && out_free) begin
            if (r_found ? !stale : free_any) begin
                o_req.wr_en = 1'b1;
                o_req.wr_addr = r_found ? r_found_slot : free_slot;
                o_req.wr_data.key = r_key;
                o_req.wr_data.deadline = deadline;
                o_req.wr_data.revision = r_rev;
                o_req.wr_data.generation = r_gen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_ovalid <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && out_if.ready) begin
                r_ovalid <= 1'b0;
            end
            r_rd_vld <= o_req.rd_en && (r_state == S_SCAN);
            r_slot <= r_idx[SLOT_W-1:0];
            case (r_state)
                S_IDLE: begin
                    if (in_if.valid) begin
                        r_op <= in_if.opcode;
                        r_key <= in_if.key_id;
                        r_ttl <= in_if.ttl_ms;
                        r_rev <= in_if.revision;
                        r_gen <= in_if.generation;
                        r_now <= in_if.now_ms;
                        r_count <= '0;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_idx[SLOT_W]) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    // compare the word returned for the previous address
                    if (r_rd_vld && r_valid[r_slot]) begin
                        if (r_op == OP_SCHEDULE) begin
                            if (!r_found && i_rd_data.key == r_key) begin
                                r_found <= 1'b1;
                                r_found_slot <= r_slot;
                                r_found_ent <= i_rd_data;
                            end
                        end else if (i_rd_data.deadline <= r_now &&
                                     (!r_best_ok || i_rd_data.deadline < r_best_dl)) begin
                            r_best_ok <= 1'b1;
                            r_best <= r_slot;
                            r_best_dl <= i_rd_data.deadline;
                        end
                    end
                    if (r_idx[SLOT_W] && !r_rd_vld) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_op == OP_SCHEDULE) begin
                        if (out_free) begin
                            r_okey <= '0;
                            r_orev <= '0;
                            r_ogen <= '0;
                            r_olast <= 1'b1;
                            if (r_ttl == 32'd0 || r_ttl[31]) begin
                                r_status <= ST_IGNORED;
                            end else if (r_found) begin
                                r_status <= stale ? ST_STALE : ST_SCHEDULED;
                            end else if (free_any) begin
                                r_status <= ST_SCHEDULED;
                                r_valid[free_slot] <= 1'b1;
                            end else begin
                                r_status <= ST_FULL;
                            end
                            r_state <= S_IDLE;
                        end
                    end else if (r_count != '0) begin
                        // a held expired word goes out; this scan decides its last flag
                        r_state <= S_OUT;
                    end else if (r_best_ok) begin
                        r_state <= S_FETCH;
                    end else begin
                        if (out_free) begin
                            r_status <= ST_NONE_DUE;
                            r_okey <= '0;
                            r_orev <= '0;
                            r_ogen <= '0;
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FETCH: begin
                    r_valid[r_best] <= 1'b0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_found_ent <= i_rd_data;
                    r_count <= r_count + 1'b1;
                    if (r_count == CNT_W'(MAX_EXP - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= '0;
                        r_best_ok <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_OUT: begin
                    // hold one expired word until the output stage is free
                    if (out_free) begin
                        r_status <= ST_EXPIRED;
                        r_okey <= r_found_ent.key;
                        r_orev <= r_found_ent.revision;
                        r_ogen <= r_found_ent.generation;
                        r_olast <= last_word;
                        r_state <= last_word ? S_IDLE : S_FETCH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/ttl_expiry_table_unit.sv =====
`timescale 1ns / 1ps
// Per-key expiry deadline table, 64 slots held in one synchronous RAM.
// Input channel i_in carries schedule (opcode 0) and check (opcode 1) words.
// Output channel o_out carries result words; last marks the final one of an item.
// A schedule reads every slot once to find the key and gives one result.
// A check scans all slots through the one RAM read port once per expired
// entry, up to 16 entries. The final word of a check is emitted after the
// next scan finds nothing more due, or without a further scan at the 16th.
// Reset clears the slot valid flags and the output register; RAM contents need
// no clearing. If the receiver stalls, one result waits in the output register
// and the controller waits to load the next word until it is taken; no word is dropped.
`include "ttl_expiry_table_unit_macros.svh"
module ttl_expiry_table_unit
    import tte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tte_in_if.sink    i_in,
    tte_out_if.source o_out
);
    t_mem_req req;
    t_entry   rd_data;

    tte_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_if(i_in), .out_if(o_out),
        .o_req(req), .i_rd_data(rd_data)
    );
    tte_mem u_mem (.i_clk(i_clk), .i_req(req), .o_rd_data(rd_data));

    `TTE_ASSERT_IMP(a_no_wr_rd_clash, i_clk, i_rst_n, req.wr_en, !req.rd_en, "write with read")
    `TTE_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "busy")
    `TTE_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_out.valid, o_out.status <= ST_NONE_DUE, "bad status")
endmodule
